// ----- hw/rtl/gtma_pkg.sv -----
`timescale 1ns / 1ps

package gtma_pkg;

   // Field widths
   localparam int TEMP_W  = 16;
   localparam int HUMI_W  = 16;
   localparam int PRESS_W = 17;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HUMI_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HUMI_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_HIGH = 3'd5;

   // Limit values after reset
   localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST   = -16'sd4000;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST  = 16'sd8500;
   localparam logic [HUMI_W-1:0]        HUMI_LOW_RST   = 16'd0;
   localparam logic [HUMI_W-1:0]        HUMI_HIGH_RST  = 16'd10000;
   localparam logic [PRESS_W-1:0]       PRESS_LOW_RST  = 17'd30000;
   localparam logic [PRESS_W-1:0]       PRESS_HIGH_RST = 17'd110000;

   localparam int WINDOW_DEFAULT = 8;

   // One ring entry: all three channels at the same position
   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic [HUMI_W-1:0]        humi;
      logic [PRESS_W-1:0]       press;
   } entry_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      CH_TEMP,
      CH_HUMI,
      CH_PRESS
   } chan_type;

endpackage

// ----- hw/rtl/gated_triple_moving_average.sv -----
`timescale 1ns / 1ps

// Moving average over the last WINDOW accepted samples of temperature,
// humidity and pressure, gated by a temperature range.
// Input channel req_*: one sample per item. req_stall is high whenever the
// block is working on an item, so one item is in flight at a time.
// Result channel rsp_*: one result per input item, held in output registers
// until taken (rsp_stall low). The block takes the next item only after the
// result has been taken, in the following cycle at the earliest.
// A sample whose temperature is outside the limits leaves the window alone
// and gives accepted=0 with zero means, offered in the cycle after it is
// taken. An accepted sample is written into the ring, the filled entries
// are summed one per cycle through one memory read port, and the three sums
// go one after another through one restoring divider of DIV_W =
// 17 + clog2(WINDOW+1) bits. Limits are to be written through csr_* only
// while the block is idle; the block itself does not enforce this.
// Synchronous reset restores the default limits and empties the window;
// only written entries are ever read, so the ring needs no clearing pass.

module gated_triple_moving_average #(
   parameter int WINDOW = gtma_pkg::WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write_en,
   input  logic [gtma_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gtma_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // input items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [gtma_pkg::TEMP_W-1:0]  req_temp_sample,
   input  logic [gtma_pkg::HUMI_W-1:0]         req_humi_sample,
   input  logic [gtma_pkg::PRESS_W-1:0]        req_press_sample,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic signed [gtma_pkg::TEMP_W-1:0]  rsp_temp_mean,
   output logic [gtma_pkg::HUMI_W-1:0]         rsp_humi_mean,
   output logic [gtma_pkg::PRESS_W-1:0]        rsp_press_mean
);

   localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int TSUM_W  = gtma_pkg::TEMP_W + CNT_W;
   localparam int HSUM_W  = gtma_pkg::HUMI_W + CNT_W;
   localparam int PSUM_W  = gtma_pkg::PRESS_W + CNT_W;
   localparam int DIV_W   = PSUM_W;

   // Limit registers
   logic signed [gtma_pkg::TEMP_W-1:0] temp_low_ff, temp_high_ff;
   logic [gtma_pkg::HUMI_W-1:0]        humi_low_ff, humi_high_ff;
   logic [gtma_pkg::PRESS_W-1:0]       press_low_ff, press_high_ff;

   // Sequencer and window state
   gtma_pkg::state_type state_ff, state_in;
   gtma_pkg::chan_type  sel_ff, sel_in;
   logic [IDX_W-1:0]    pos_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic                rd_vld_ff;

   // Datapath
   gtma_pkg::entry_type        entry_ff;
   gtma_pkg::entry_type        clamped;
   gtma_pkg::entry_type        rd_data;
   logic signed [TSUM_W-1:0]   tsum_ff;
   logic [HSUM_W-1:0]          hsum_ff;
   logic [PSUM_W-1:0]          psum_ff;
   logic [TSUM_W-1:0]          tmag;
   logic [DIV_W-1:0]           dividend;
   logic [DIV_W-1:0]           quotient;
   logic [DIV_W-1:0]           tquo;
   gtma_pkg::div_status_type   div_status;

   logic                       accepted_ff;
   logic signed [gtma_pkg::TEMP_W-1:0] temp_mean_ff;
   logic [gtma_pkg::HUMI_W-1:0]        humi_mean_ff;
   logic [gtma_pkg::PRESS_W-1:0]       press_mean_ff;

   // Control decoded from state
   logic take;
   logic pass;
   logic mem_we;
   logic rd_issue;
   logic div_start;
   logic sums_done;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_low_ff   <= gtma_pkg::TEMP_LOW_RST;
         temp_high_ff  <= gtma_pkg::TEMP_HIGH_RST;
         humi_low_ff   <= gtma_pkg::HUMI_LOW_RST;
         humi_high_ff  <= gtma_pkg::HUMI_HIGH_RST;
         press_low_ff  <= gtma_pkg::PRESS_LOW_RST;
         press_high_ff <= gtma_pkg::PRESS_HIGH_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            gtma_pkg::CSR_TEMP_LOW:   temp_low_ff   <= csr_wdata[gtma_pkg::TEMP_W-1:0];
            gtma_pkg::CSR_TEMP_HIGH:  temp_high_ff  <= csr_wdata[gtma_pkg::TEMP_W-1:0];
            gtma_pkg::CSR_HUMI_LOW:   humi_low_ff   <= csr_wdata[gtma_pkg::HUMI_W-1:0];
            gtma_pkg::CSR_HUMI_HIGH:  humi_high_ff  <= csr_wdata[gtma_pkg::HUMI_W-1:0];
            gtma_pkg::CSR_PRESS_LOW:  press_low_ff  <= csr_wdata;
            gtma_pkg::CSR_PRESS_HIGH: press_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Gate on temperature, clamp humidity and pressure
   always_comb begin
      pass = (req_temp_sample >= temp_low_ff) && (req_temp_sample <= temp_high_ff);
      clamped.temp = req_temp_sample;
      if (req_humi_sample < humi_low_ff) begin
         clamped.humi = humi_low_ff;
      end else if (req_humi_sample > humi_high_ff) begin
         clamped.humi = humi_high_ff;
      end else begin
         clamped.humi = req_humi_sample;
      end
      if (req_press_sample < press_low_ff) begin
         clamped.press = press_low_ff;
      end else if (req_press_sample > press_high_ff) begin
         clamped.press = press_high_ff;
      end else begin
         clamped.press = req_press_sample;
      end
   end

   assign take      = req_valid && !req_stall;
   assign sums_done = (idx_ff == fill_ff) && !rd_vld_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         gtma_pkg::ST_IDLE: begin
            if (take) begin
               state_in = pass ? gtma_pkg::ST_WRITE : gtma_pkg::ST_OUT;
            end
         end
         gtma_pkg::ST_WRITE: state_in = gtma_pkg::ST_SUM;
         gtma_pkg::ST_SUM: begin
            if (sums_done) begin
               state_in = gtma_pkg::ST_DIV_START;
               sel_in   = gtma_pkg::CH_TEMP;
            end
         end
         gtma_pkg::ST_DIV_START: state_in = gtma_pkg::ST_DIV_WAIT;
         gtma_pkg::ST_DIV_WAIT: begin
            if (div_status.done) begin
               unique case (sel_ff)
                  gtma_pkg::CH_TEMP: begin
                     sel_in   = gtma_pkg::CH_HUMI;
                     state_in = gtma_pkg::ST_DIV_START;
                  end
                  gtma_pkg::CH_HUMI: begin
                     sel_in   = gtma_pkg::CH_PRESS;
                     state_in = gtma_pkg::ST_DIV_START;
                  end
                  default: state_in = gtma_pkg::ST_OUT;
               endcase
            end
         end
         gtma_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = gtma_pkg::ST_IDLE;
            end
         end
         default: state_in = gtma_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      mem_we    = 1'b0;
      rd_issue  = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         gtma_pkg::ST_IDLE:      req_stall = 1'b0;
         gtma_pkg::ST_WRITE:     mem_we    = 1'b1;
         gtma_pkg::ST_SUM:       rd_issue  = (idx_ff != fill_ff);
         gtma_pkg::ST_DIV_START: div_start = 1'b1;
         gtma_pkg::ST_DIV_WAIT:  ;
         gtma_pkg::ST_OUT:       rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gtma_pkg::ST_IDLE;
         sel_ff    <= gtma_pkg::CH_TEMP;
         pos_ff    <= '0;
         fill_ff   <= '0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sel_ff    <= sel_in;
         rd_vld_ff <= rd_issue;
         // Advance write position and fill count
         if (mem_we) begin
            pos_ff <= (pos_ff == IDX_W'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
            if (fill_ff != CNT_W'(WINDOW)) begin
               fill_ff <= fill_ff + 1'b1;
            end
            idx_ff <= '0;
         end else if (rd_issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // Hold the gated sample
   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff <= clamped;
      end
   end

   gtma_ring #(
      .WINDOW (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (pos_ff),
      .wr_data (entry_ff),
      .rd_en   (rd_issue),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Accumulate the filled entries
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tsum_ff <= '0;
         hsum_ff <= '0;
         psum_ff <= '0;
      end else if (rd_vld_ff) begin
         tsum_ff <= tsum_ff + TSUM_W'(rd_data.temp);
         hsum_ff <= hsum_ff + HSUM_W'(rd_data.humi);
         psum_ff <= psum_ff + PSUM_W'(rd_data.press);
      end
   end

   // Feed the divider one channel at a time; temperature as a magnitude
   always_comb begin
      tmag = tsum_ff[TSUM_W-1] ? TSUM_W'(-tsum_ff) : TSUM_W'(tsum_ff);
      case (sel_ff)
         gtma_pkg::CH_TEMP:  dividend = DIV_W'(tmag);
         gtma_pkg::CH_HUMI:  dividend = DIV_W'(hsum_ff);
         default:            dividend = psum_ff;
      endcase
   end

   gtma_div #(
      .DIV_W (DIV_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (fill_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   // Restore the sign of the temperature mean
   assign tquo = tsum_ff[TSUM_W-1] ? DIV_W'(-quotient) : quotient;

   // Result registers
   always_ff @(posedge clock) begin
      if (take && !pass) begin
         accepted_ff   <= 1'b0;
         temp_mean_ff  <= '0;
         humi_mean_ff  <= '0;
         press_mean_ff <= '0;
      end else if (state_ff == gtma_pkg::ST_DIV_WAIT && div_status.done) begin
         accepted_ff <= 1'b1;
         case (sel_ff)
            gtma_pkg::CH_TEMP:  temp_mean_ff  <= tquo[gtma_pkg::TEMP_W-1:0];
            gtma_pkg::CH_HUMI:  humi_mean_ff  <= quotient[gtma_pkg::HUMI_W-1:0];
            default:            press_mean_ff <= quotient[gtma_pkg::PRESS_W-1:0];
         endcase
      end
   end

   assign rsp_accepted   = accepted_ff;
   assign rsp_temp_mean  = temp_mean_ff;
   assign rsp_humi_mean  = humi_mean_ff;
   assign rsp_press_mean = press_mean_ff;

endmodule

// ----- hw/rtl/gtma_ring.sv -----
`timescale 1ns / 1ps

module gtma_ring #(
   parameter int WINDOW = gtma_pkg::WINDOW_DEFAULT,
   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  gtma_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output gtma_pkg::entry_type rd_data
);

   gtma_pkg::entry_type mem [WINDOW];
   gtma_pkg::entry_type rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/gtma_div.sv -----
`timescale 1ns / 1ps

module gtma_div #(
   parameter int DIV_W = 21,
   parameter int DEN_W = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIV_W-1:0]        dividend,
   input  logic [DEN_W-1:0]        divisor,
   output gtma_pkg::div_status_type status,
   output logic [DIV_W-1:0]        quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] work_ff, work_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   // One restoring step: bring down the next dividend bit, try the subtract
   always_comb begin
      rem_sh  = {rem_ff, work_ff[DIV_W-1]};
      fits    = (rem_sh >= {1'b0, den_ff});
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         work_in = dividend;
         quo_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[DIV_W-2:0], 1'b0};
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         rem_in  = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule
